FILE: hw/rtl/iphd_pkg.sv
// ----------------------------------------------------------------------------
// iphd_pkg
// Shared constants, types and the arctangent table for the heading core.
// ----------------------------------------------------------------------------
package iphd_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Quotient of 100 * min / max is at most 100, so 7 bits cover it
    localparam int QUOT_BITS = 7;
    localparam int QUOT_MAX  = 100;
    localparam int ANG_BITS  = 6;
    localparam int HEAD_BITS = 9;

    localparam int DEG_90  = 90;
    localparam int DEG_180 = 180;
    localparam int DEG_360 = 360;

    // Exact quotients that step down one table entry
    localparam int FIX_Q0 = 29;
    localparam int FIX_Q1 = 57;
    localparam int FIX_Q2 = 58;

    // Side information carried beside the divider data
    typedef struct packed {
        logic vld;
        logic zero;
        logic steep;
        logic xneg;
        logic yneg;
    } t_side;

    // trunc(atan(i / 100) * 57.2957795), i = 0..100
    localparam logic [ANG_BITS-1:0] ATAN_ROM [0:QUOT_MAX] = '{
        6'd0,  6'd0,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd4,  6'd5,
        6'd5,  6'd6,  6'd6,  6'd7,  6'd7,  6'd8,  6'd9,  6'd9,  6'd10, 6'd10,
        6'd11, 6'd11, 6'd12, 6'd12, 6'd13, 6'd14, 6'd14, 6'd15, 6'd15, 6'd16,
        6'd16, 6'd17, 6'd17, 6'd18, 6'd18, 6'd19, 6'd19, 6'd20, 6'd20, 6'd21,
        6'd21, 6'd22, 6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26,
        6'd26, 6'd27, 6'd27, 6'd27, 6'd28, 6'd28, 6'd29, 6'd29, 6'd30, 6'd30,
        6'd30, 6'd31, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd34, 6'd34,
        6'd34, 6'd35, 6'd35, 6'd36, 6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38,
        6'd38, 6'd39, 6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd41, 6'd41, 6'd41,
        6'd41, 6'd42, 6'd42, 6'd42, 6'd43, 6'd43, 6'd43, 6'd44, 6'd44, 6'd44,
        6'd44
    };

    function automatic logic [ANG_BITS-1:0] atan_deg(input logic [QUOT_BITS-1:0] idx);
        logic [ANG_BITS-1:0] res;
        if (idx > QUOT_BITS'(QUOT_MAX)) begin
            res = ATAN_ROM[QUOT_MAX];
        end else begin
            res = ATAN_ROM[idx];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/integer_point_heading_degrees_core.sv
// ----------------------------------------------------------------------------
// integer_point_heading_degrees_core
// Whole-degree heading (0..359) from two signed integer points.
// ----------------------------------------------------------------------------
// One point pair is taken every clock while the output side is ready; each
// result passes through two delta/magnitude stages, a row of seven divider
// cells that each resolve one bit of 100*min/max, and the table/quadrant
// output register. The whole pipe holds when a result is waiting on the
// output and the consumer is not ready.
module integer_point_heading_degrees_core #(
    parameter int COORD_BITS = iphd_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // from_x, from_y, to_x, to_y (lowest first), zero padded to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // heading[8:0], zero padded
    output logic [15:0]                         m_axis_tdata
);

    localparam int QB = iphd_pkg::QUOT_BITS;
    localparam int RW = COORD_BITS + 8;
    localparam int DW = COORD_BITS + 1;

    logic w_en;

    iphd_pkg::t_side w_side [0:QB];
    logic [RW-1:0]   w_rem  [0:QB];
    logic [DW-1:0]   w_den  [0:QB];
    logic [QB-1:0]   w_quot [0:QB];

    logic                          r_out_vld;
    logic [iphd_pkg::HEAD_BITS-1:0] r_heading;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    iphd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (s_axis_tvalid),
        .i_from_x (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .i_from_y (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .i_to_x   (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_to_y   (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
        .o_side   (w_side[0]),
        .o_rem    (w_rem[0]),
        .o_den    (w_den[0])
    );

    assign w_quot[0] = '0;

    for (genvar j = 0; j < QB; j++) begin : g_cell
        iphd_cell #(
            .COORD_BITS (COORD_BITS),
            .SHIFT      (QB - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_side[j]),
            .i_rem   (w_rem[j]),
            .i_den   (w_den[j]),
            .i_quot  (w_quot[j]),
            .o_side  (w_side[j+1]),
            .o_rem   (w_rem[j+1]),
            .o_den   (w_den[j+1]),
            .o_quot  (w_quot[j+1])
        );
    end

    // Table lookup and quadrant fold
    iphd_pkg::t_side                   w_fs;
    logic [QB-1:0]                     w_q;
    logic                              w_fix;
    logic [QB-1:0]                     w_idx;
    logic [iphd_pkg::ANG_BITS-1:0]     w_t;
    logic signed [10:0]                w_ang;
    logic [iphd_pkg::HEAD_BITS-1:0]    n_heading;

    assign w_fs  = w_side[QB];
    assign w_q   = w_quot[QB];
    // exact quotients 29, 57 and 58 step down one entry
    assign w_fix = (w_rem[QB] == '0)
                && (w_q == QB'(iphd_pkg::FIX_Q0) || w_q == QB'(iphd_pkg::FIX_Q1)
                    || w_q == QB'(iphd_pkg::FIX_Q2));
    assign w_idx = w_fix ? (w_q - QB'(1)) : w_q;
    assign w_t   = iphd_pkg::atan_deg(w_idx);

    always_comb begin
        w_ang = 11'(w_t);
        if (w_fs.steep) begin
            w_ang = 11'(iphd_pkg::DEG_90) - w_ang;
        end
        priority if (w_fs.xneg && !w_fs.yneg) begin
            w_ang = 11'(iphd_pkg::DEG_180) - w_ang;
        end else if (w_fs.xneg && w_fs.yneg) begin
            w_ang = w_ang + 11'(iphd_pkg::DEG_180);
        end else if (!w_fs.xneg && w_fs.yneg) begin
            w_ang = -w_ang;
        end else begin
            w_ang = w_ang;
        end
        w_ang = w_ang - 11'(iphd_pkg::DEG_90);
        if (w_ang < 0) begin
            w_ang = w_ang + 11'(iphd_pkg::DEG_360);
        end
        if (w_fs.zero) begin
            n_heading = '0;
        end else begin
            n_heading = w_ang[iphd_pkg::HEAD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_fs.vld;
        end
        if (w_en) begin
            r_heading <= n_heading;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(16 - iphd_pkg::HEAD_BITS){1'b0}}, r_heading};

endmodule

FILE: hw/rtl/iphd_front.sv
// ----------------------------------------------------------------------------
// iphd_front
// Delta, magnitude and steepness stages; forms 100 * min and max for the divider.
// ----------------------------------------------------------------------------
module iphd_front #(
    parameter int COORD_BITS = iphd_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [COORD_BITS-1:0]   i_from_x,
    input  logic [COORD_BITS-1:0]   i_from_y,
    input  logic [COORD_BITS-1:0]   i_to_x,
    input  logic [COORD_BITS-1:0]   i_to_y,
    output iphd_pkg::t_side         o_side,
    output logic [COORD_BITS+7:0]   o_rem,
    output logic [COORD_BITS:0]     o_den
);

    localparam int DW = COORD_BITS + 1;
    localparam int RW = COORD_BITS + 8;

    logic                 r_vld1;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic signed [DW-1:0] n_dx;
    logic signed [DW-1:0] n_dy;

    logic [DW-1:0]   w_ax;
    logic [DW-1:0]   w_ay;
    logic            w_steep;
    logic [DW-1:0]   w_num;
    logic [DW-1:0]   w_den;
    logic [RW-1:0]   w_prod;
    iphd_pkg::t_side n_side;
    iphd_pkg::t_side r_side;
    logic [RW-1:0]   r_rem;
    logic [DW-1:0]   r_den;

    assign n_dx = $signed({i_from_x[COORD_BITS-1], i_from_x})
                - $signed({i_to_x[COORD_BITS-1], i_to_x});
    assign n_dy = $signed({i_from_y[COORD_BITS-1], i_from_y})
                - $signed({i_to_y[COORD_BITS-1], i_to_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
        if (i_en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    // Magnitude fits DW bits unsigned, including the most negative delta
    assign w_ax    = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign w_ay    = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    assign w_steep = w_ax < w_ay;
    assign w_num   = w_steep ? w_ax : w_ay;
    assign w_den   = w_steep ? w_ay : w_ax;
    // 100 = 64 + 32 + 4
    assign w_prod  = (RW'(w_num) << 6) + (RW'(w_num) << 5) + (RW'(w_num) << 2);

    always_comb begin
        n_side.vld   = r_vld1;
        n_side.zero  = (w_den == '0);
        n_side.steep = w_steep;
        n_side.xneg  = r_dx[DW-1];
        n_side.yneg  = r_dy[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= n_side;
        end
        if (i_en) begin
            r_rem <= w_prod;
            r_den <= w_den;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_den  = r_den;

endmodule

FILE: hw/rtl/iphd_cell.sv
// ----------------------------------------------------------------------------
// iphd_cell
// One restoring-division cell: settles one quotient bit and passes the rest on.
// ----------------------------------------------------------------------------
module iphd_cell #(
    parameter int COORD_BITS = iphd_pkg::COORD_BITS_DEF,
    parameter int SHIFT      = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  iphd_pkg::t_side                 i_side,
    input  logic [COORD_BITS+7:0]           i_rem,
    input  logic [COORD_BITS:0]             i_den,
    input  logic [iphd_pkg::QUOT_BITS-1:0]  i_quot,
    output iphd_pkg::t_side                 o_side,
    output logic [COORD_BITS+7:0]           o_rem,
    output logic [COORD_BITS:0]             o_den,
    output logic [iphd_pkg::QUOT_BITS-1:0]  o_quot
);

    localparam int RW = COORD_BITS + 8;

    logic [RW-1:0]                    w_dsh;
    logic                             w_ge;
    logic [RW-1:0]                    n_rem;
    logic [iphd_pkg::QUOT_BITS-1:0]   n_quot;
    iphd_pkg::t_side                  r_side;
    logic [RW-1:0]                    r_rem;
    logic [COORD_BITS:0]              r_den;
    logic [iphd_pkg::QUOT_BITS-1:0]   r_quot;

    assign w_dsh = RW'(i_den) << SHIFT;
    assign w_ge  = i_rem >= w_dsh;
    assign n_rem = w_ge ? (i_rem - w_dsh) : i_rem;

    always_comb begin
        n_quot        = i_quot;
        n_quot[SHIFT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quot = r_quot;

endmodule
